>>> rtl/core/bsed_pkg.sv
`default_nettype none

package bsed_pkg;

  // One input item: a raw byte or an end-of-text mark
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_OCT   = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic REG_ESCAPE_ENABLE = 1'b0;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;

  // Control bytes for the simple escapes
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_BEL = 8'd7;
  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_FF  = 8'd12;
  localparam logic [7:0] BYTE_VT  = 8'd11;

  // Digit limits of the numeric escapes
  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/backslash_escape_decoder.sv
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | char_in, end_of_text
// out_    | output    | out_valid/out_stall| out_byte, last_of_run
// cfg_    | input     | APB, pready high   | escape_enable at address 0
//
// One item is accepted per cycle while in_stall is low; the decode of an item is done
// in the cycle it is accepted and its zero, one or two results land in a four-entry
// result queue. Results leave one per cycle while out_stall is low, so the two results
// of an item leave in turn. in_stall rises while fewer than two queue slots are free.
// Synchronous active-low reset empties the queue, clears the mode and disables decoding.

module backslash_escape_decoder (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  bsed_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output bsed_pkg::out_item_t   out_data,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire  [2:0]            cfg_paddr,
  input  wire  [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  // Configuration register
  logic esc_en_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == bsed_pkg::REG_ESCAPE_ENABLE)) begin
      esc_en_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == bsed_pkg::REG_ESCAPE_ENABLE) begin
      cfg_prdata = {31'd0, esc_en_r};
    end
  end

  // Decoder state
  bsed_pkg::mode_t mode_r, mode_nxt;
  logic [8:0]      acc_r, acc_nxt;
  logic [1:0]      dcnt_r, dcnt_nxt;

  // Result queue
  bsed_pkg::out_item_t q_r [QDEPTH];
  logic [QPW-1:0]      wr_r, rd_r;
  logic [QPW:0]        cnt_r, cnt_nxt;

  logic       in_acc, out_acc;
  logic [1:0] n_res;
  logic [7:0] b0, b1;
  logic [7:0] c;
  logic       eot;
  logic       hex_ok, oct_ok;
  logic [3:0] hex_d;
  logic [8:0] acc_hex, acc_oct;
  logic [1:0] dcnt_inc;

  assign c   = in_data.char_in;
  assign eot = in_data.end_of_text;

  assign in_stall  = (cnt_r > (QPW+1)'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = q_r[rd_r];

  // Digit classification
  always_comb begin
    hex_ok = 1'b0;
    hex_d  = c[3:0];
    if (c inside {[bsed_pkg::CH_0 : bsed_pkg::CH_9]}) begin
      hex_ok = 1'b1;
    end else if (c inside {[bsed_pkg::CH_LC_A : bsed_pkg::CH_LC_F],
                           [bsed_pkg::CH_UC_A : bsed_pkg::CH_UC_F]}) begin
      hex_ok = 1'b1;
      hex_d  = c[3:0] + 4'd9;
    end
    oct_ok = (c inside {[bsed_pkg::CH_0 : bsed_pkg::CH_7]});
  end

  assign acc_hex  = {acc_r[4:0], hex_d};
  assign acc_oct  = {acc_r[5:0], c[2:0]};
  assign dcnt_inc = dcnt_r + 2'd1;

  // Per-item decode: next state and up to two result bytes
  always_comb begin
    n_res    = 2'd0;
    b0       = 8'd0;
    b1       = c;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    if (!esc_en_r) begin
      mode_nxt = bsed_pkg::MODE_PLAIN;
      acc_nxt  = '0;
      dcnt_nxt = '0;
      if (!eot) begin
        n_res = 2'd1;
        b0    = c;
      end
    end else if (eot) begin
      case (mode_r)
        bsed_pkg::MODE_ESC: begin
          n_res    = 2'd1;
          b0       = bsed_pkg::CH_BSLASH;
          mode_nxt = bsed_pkg::MODE_PLAIN;
        end
        bsed_pkg::MODE_HEX, bsed_pkg::MODE_OCT: begin
          n_res    = 2'd1;
          b0       = acc_r[7:0];
          mode_nxt = bsed_pkg::MODE_PLAIN;
          acc_nxt  = '0;
          dcnt_nxt = '0;
        end
        default: ;
      endcase
    end else begin
      case (mode_r)
        bsed_pkg::MODE_PLAIN: begin
          if (c == bsed_pkg::CH_BSLASH) begin
            mode_nxt = bsed_pkg::MODE_ESC;
          end else begin
            n_res = 2'd1;
            b0    = c;
          end
        end
        bsed_pkg::MODE_ESC: begin
          mode_nxt = bsed_pkg::MODE_PLAIN;
          n_res    = 2'd1;
          case (c)
            bsed_pkg::CH_N:      b0 = bsed_pkg::BYTE_LF;
            bsed_pkg::CH_T:      b0 = bsed_pkg::BYTE_TAB;
            bsed_pkg::CH_R:      b0 = bsed_pkg::BYTE_CR;
            bsed_pkg::CH_LC_A:   b0 = bsed_pkg::BYTE_BEL;
            bsed_pkg::CH_B:      b0 = bsed_pkg::BYTE_BS;
            bsed_pkg::CH_F:      b0 = bsed_pkg::BYTE_FF;
            bsed_pkg::CH_V:      b0 = bsed_pkg::BYTE_VT;
            bsed_pkg::CH_X: begin
              n_res    = 2'd0;
              mode_nxt = bsed_pkg::MODE_HEX;
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end
            bsed_pkg::CH_0: begin
              n_res    = 2'd0;
              mode_nxt = bsed_pkg::MODE_OCT;
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end
            default:             b0 = c;
          endcase
        end
        default: begin
          // Numeric escape: take a digit, or close the escape and rehandle the byte
          if ((mode_r == bsed_pkg::MODE_HEX) ? hex_ok : oct_ok) begin
            if (dcnt_inc >= ((mode_r == bsed_pkg::MODE_HEX) ? bsed_pkg::HEX_DIGITS
                                                             : bsed_pkg::OCT_DIGITS)) begin
              n_res    = 2'd1;
              b0       = (mode_r == bsed_pkg::MODE_HEX) ? acc_hex[7:0] : acc_oct[7:0];
              mode_nxt = bsed_pkg::MODE_PLAIN;
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end else begin
              acc_nxt  = (mode_r == bsed_pkg::MODE_HEX) ? acc_hex : acc_oct;
              dcnt_nxt = dcnt_inc;
            end
          end else begin
            b0       = acc_r[7:0];
            acc_nxt  = '0;
            dcnt_nxt = '0;
            if (c == bsed_pkg::CH_BSLASH) begin
              n_res    = 2'd1;
              mode_nxt = bsed_pkg::MODE_ESC;
            end else begin
              n_res    = 2'd2;
              mode_nxt = bsed_pkg::MODE_PLAIN;
            end
          end
        end
      endcase
    end
  end

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bsed_pkg::MODE_PLAIN;
      acc_r  <= '0;
      dcnt_r <= '0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  // Queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + {{(QPW-1){1'b0}}, n_res};
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        wr_r <= wr_r + QPW'(n_res);
      end
      if (out_acc) begin
        rd_r <= rd_r + QPW'(1);
      end
    end
  end

  // Queue payload: first result at the write pointer, second just after it
  always_ff @(posedge clk) begin
    if (in_acc && (n_res != 2'd0)) begin
      q_r[wr_r].out_byte    <= b0;
      q_r[wr_r].last_of_run <= (n_res == 2'd1);
    end
    if (in_acc && (n_res == 2'd2)) begin
      q_r[wr_r + QPW'(1)].out_byte    <= b1;
      q_r[wr_r + QPW'(1)].last_of_run <= 1'b1;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPW+1)'(QDEPTH))
    else $error("result queue overflow");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_data.last_of_run) |=> out_valid)
    else $error("non-final result without its partner queued");

  a_disabled_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !esc_en_r) |=> (mode_r == bsed_pkg::MODE_PLAIN))
    else $error("pending escape kept with decoding off");

  a_idle_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == bsed_pkg::MODE_PLAIN) || (mode_r == bsed_pkg::MODE_ESC))
      |-> ((acc_r == '0) && (dcnt_r == '0)))
    else $error("accumulator not cleared outside numeric escape");

  a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == bsed_pkg::MODE_HEX) |-> (dcnt_r < bsed_pkg::HEX_DIGITS)) and
    ((mode_r == bsed_pkg::MODE_OCT) |-> (dcnt_r < bsed_pkg::OCT_DIGITS)))
    else $error("digit count past escape limit");

endmodule

`default_nettype wire
